// ----- sv/retransmit_timer_queue_defines.svh -----
// Assertion macros for the retransmit timer queue.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef RETRANSMIT_TIMER_QUEUE_DEFINES_SVH
`define RETRANSMIT_TIMER_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define RTQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtq check failed");
`define RTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtq check failed");
`else
`define RTQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/rtq_pkg.sv -----
// Shared types, codes and reset constants for the retransmit timer queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package rtq_pkg;

  localparam int RTQ_DEPTH  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 33;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IS_SERVER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIN_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 3'd4;

  // Register reset values
  localparam logic [7:0]  RETRY_LIMIT_RST = 8'd5;
  localparam logic [7:0]  FIN_LIMIT_RST   = 8'd3;
  localparam logic [15:0] TIMEOUT_RST     = 16'd500;
  localparam logic [32:0] MODULUS_RST     = 33'd30720;

  // Request functions
  localparam logic [1:0] FUNC_SEND = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_ACK  = 2'd2;

  // Outcome codes
  localparam logic [2:0] OC_TRANSMIT     = 3'd0;
  localparam logic [2:0] OC_RETRANSMIT   = 3'd1;
  localparam logic [2:0] OC_GIVEN_UP     = 3'd2;
  localparam logic [2:0] OC_FIN_GIVEN_UP = 3'd3;
  localparam logic [2:0] OC_ACKED        = 3'd4;
  localparam logic [2:0] OC_NO_MATCH     = 3'd5;
  localparam logic [2:0] OC_FULL         = 3'd6;
  localparam logic [2:0] OC_IDLE         = 3'd7;

  // One tracked segment; sum is seq + length, kept for ack matching
  typedef struct packed {
    logic [31:0] seq;
    logic [9:0]  len;
    logic        fin;
    logic [7:0]  retries;
    logic [47:0] deadline;
    logic [32:0] sum;
  } rtq_entry_t;

  // Commands broadcast from the controller to every cell
  typedef struct packed {
    logic        capture;
    logic [31:0] ack;
    logic [32:0] modulus;
    logic        append;
    logic        drop_head;
    logic        rotate;
    logic        ack_rm;
    rtq_entry_t  ins;
  } rtq_ctl_t;

endpackage

// ----- sv/retransmit_timer_queue.sv -----
// Retransmit timer queue: no new request is taken while busy. Accept at start && !busy; busy is
// high for the one execute cycle, in which the row of cells compares, shifts or appends.
// The result strobes on out_valid for one cycle as busy falls; the next request
// may be accepted in that same cycle. The ack match is taken in every cell at accept.
// Synchronous active-low reset empties the table and loads the register defaults.
// Depends on rtq_pkg, rtq_ctrl, rtq_cell and the assertion macro header.
`timescale 1ns / 1ps
`include "retransmit_timer_queue_defines.svh"
module retransmit_timer_queue
  import rtq_pkg::*;
#(
  parameter int TABLE_DEPTH = RTQ_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_func,
  input  logic [31:0]           in_seq_num,
  input  logic [9:0]            in_data_length,
  input  logic                  in_is_fin,
  input  logic                  in_needs_ack,
  input  logic [31:0]           in_ack_num,
  input  logic [47:0]           in_now_ms,
  output logic                  out_valid,
  output logic [2:0]            out_outcome,
  output logic [31:0]           out_seq,
  output logic [9:0]            out_length,
  output logic                  out_fin,
  output logic [7:0]            out_retries,
  output logic                  out_stop_request,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic        is_server_r;
  logic [7:0]  retry_limit_r;
  logic [7:0]  fin_limit_r;
  logic [15:0] timeout_r;
  logic [32:0] modulus_r;

  rtq_ctl_t                 ctl;
  logic [TABLE_DEPTH-1:0]   valid_vec;
  logic [TABLE_DEPTH-1:0]   first_hit_vec;
  logic [TABLE_DEPTH:0]     hit_chain;
  rtq_entry_t               entry_arr [TABLE_DEPTH];
  rtq_entry_t               hit_entry;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_server_r   <= 1'b0;
      retry_limit_r <= RETRY_LIMIT_RST;
      fin_limit_r   <= FIN_LIMIT_RST;
      timeout_r     <= TIMEOUT_RST;
      modulus_r     <= MODULUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IS_SERVER:   is_server_r   <= cfg_wdata[0];
        CFG_RETRY_LIMIT: retry_limit_r <= cfg_wdata[7:0];
        CFG_FIN_LIMIT:   fin_limit_r   <= cfg_wdata[7:0];
        CFG_TIMEOUT:     timeout_r     <= cfg_wdata[15:0];
        CFG_MODULUS:     modulus_r     <= cfg_wdata[32:0];
        default: begin
        end
      endcase
    end
  end

  assign hit_chain[0] = 1'b0;

  // Row of cells, head at index 0
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic       prev_valid;
    logic       next_valid;
    rtq_entry_t next_entry;
    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = valid_vec[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_entry = '0;
    end else begin : g_link
      assign next_valid = valid_vec[i+1];
      assign next_entry = entry_arr[i+1];
    end
    rtq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .prev_valid (prev_valid),
      .prev_hit   (hit_chain[i]),
      .next_valid (next_valid),
      .next_entry (next_entry),
      .valid      (valid_vec[i]),
      .entry      (entry_arr[i]),
      .hit_out    (hit_chain[i+1]),
      .first_hit  (first_hit_vec[i])
    );
  end

  // Select the oldest matching entry
  always_comb begin
    hit_entry = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_entry = hit_entry | (entry_arr[i] & {$bits(rtq_entry_t){first_hit_vec[i]}});
    end
  end

  rtq_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_seq_num       (in_seq_num),
    .in_data_length   (in_data_length),
    .in_is_fin        (in_is_fin),
    .in_needs_ack     (in_needs_ack),
    .in_ack_num       (in_ack_num),
    .in_now_ms        (in_now_ms),
    .cfg_is_server    (is_server_r),
    .cfg_retry_limit  (retry_limit_r),
    .cfg_fin_limit    (fin_limit_r),
    .cfg_timeout      (timeout_r),
    .cfg_modulus      (modulus_r),
    .head_valid       (valid_vec[0]),
    .head_entry       (entry_arr[0]),
    .full             (valid_vec[TABLE_DEPTH-1]),
    .any_hit          (hit_chain[TABLE_DEPTH]),
    .hit_entry        (hit_entry),
    .ctl              (ctl),
    .out_valid        (out_valid),
    .out_outcome      (out_outcome),
    .out_seq          (out_seq),
    .out_length       (out_length),
    .out_fin          (out_fin),
    .out_retries      (out_retries),
    .out_stop_request (out_stop_request)
  );

  // Valid slots stay a compact prefix from the head
  `RTQ_ASSERT_IMPLY(a_valid_prefix, clk, rst_n, 1'b1, (valid_vec & (valid_vec + 1'b1)) == '0)
  // After execute, busy drops and one result is strobed
  `RTQ_ASSERT_NEXT(a_one_cycle_exec, clk, rst_n, busy, !busy && out_valid)
  // An ack removes at most one entry
  `RTQ_ASSERT_IMPLY(a_single_hit, clk, rst_n, ctl.ack_rm, $onehot(first_hit_vec))
  // An append grows the table by exactly one entry
  `RTQ_ASSERT_NEXT(a_append_grows, clk, rst_n, ctl.append, $countones(valid_vec) == ($past($countones(valid_vec)) + 1))

endmodule

// ----- sv/rtq_cell.sv -----
// One slot of the segment table: holds an entry, shifts toward the head.
// Depends on rtq_pkg for the entry and command types.
`timescale 1ns / 1ps
module rtq_cell
  import rtq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  rtq_ctl_t   ctl,
  input  logic       prev_valid,
  input  logic       prev_hit,
  input  logic       next_valid,
  input  rtq_entry_t next_entry,
  output logic       valid,
  output rtq_entry_t entry,
  output logic       hit_out,
  output logic       first_hit
);

  logic       valid_r, valid_nxt;
  rtq_entry_t entry_r, entry_nxt;
  logic       match_r, match_nxt;
  logic       own_hit;
  logic       shift;
  logic [32:0] sum_adj;

  // Chain the ack hit so every cell from the oldest match onward shifts
  assign own_hit   = match_r && valid_r;
  assign hit_out   = prev_hit || own_hit;
  assign first_hit = own_hit && !prev_hit;
  assign shift     = ctl.drop_head || ctl.rotate || (ctl.ack_rm && hit_out);

  // Reduce the stored sum once and compare against the ack
  assign sum_adj   = (entry_r.sum >= ctl.modulus) ? entry_r.sum - ctl.modulus : entry_r.sum;
  assign match_nxt = (sum_adj == {1'b0, ctl.ack});

  // Shift from the neighbor, insert at the tail, or append into the first free slot
  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (shift) begin
      if (next_valid) begin
        valid_nxt = 1'b1;
        entry_nxt = next_entry;
      end else if (ctl.rotate && valid_r) begin
        valid_nxt = 1'b1;
        entry_nxt = ctl.ins;
      end else begin
        valid_nxt = 1'b0;
      end
    end else if (ctl.append && !valid_r && prev_valid) begin
      valid_nxt = 1'b1;
      entry_nxt = ctl.ins;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold payload and the captured match flag
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctl.capture) begin
      match_r <= match_nxt;
    end
  end

  assign valid = valid_r;
  assign entry = entry_r;

endmodule

// ----- sv/rtq_ctrl.sv -----
// Request sequencer: captures a request, decides the table command, registers the result.
// Depends on rtq_pkg for codes and types.
`timescale 1ns / 1ps
module rtq_ctrl
  import rtq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_seq_num,
  input  logic [9:0]  in_data_length,
  input  logic        in_is_fin,
  input  logic        in_needs_ack,
  input  logic [31:0] in_ack_num,
  input  logic [47:0] in_now_ms,
  input  logic        cfg_is_server,
  input  logic [7:0]  cfg_retry_limit,
  input  logic [7:0]  cfg_fin_limit,
  input  logic [15:0] cfg_timeout,
  input  logic [32:0] cfg_modulus,
  input  logic        head_valid,
  input  rtq_entry_t  head_entry,
  input  logic        full,
  input  logic        any_hit,
  input  rtq_entry_t  hit_entry,
  output rtq_ctl_t    ctl,
  output logic        out_valid,
  output logic [2:0]  out_outcome,
  output logic [31:0] out_seq,
  output logic [9:0]  out_length,
  output logic        out_fin,
  output logic [7:0]  out_retries,
  output logic        out_stop_request
);

  logic        busy_r;
  logic [1:0]  req_func_r;
  logic [31:0] req_seq_r;
  logic [9:0]  req_len_r;
  logic        req_fin_r;
  logic        req_need_r;
  logic [47:0] req_now_r;

  logic        out_valid_r;
  logic [2:0]  outcome_r, outcome_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [9:0]  len_r, len_nxt;
  logic        fin_r, fin_nxt;
  logic [7:0]  retries_r, retries_nxt;
  logic        stop_r, stop_nxt;

  logic        accept;
  logic [47:0] deadline_new;
  logic [8:0]  retry_inc;
  logic        tick_due;
  logic        give_up;
  logic        fin_give_up;
  logic        append, drop_head, rotate, ack_rm;
  rtq_entry_t  ins;

  assign accept = start && !busy_r;

  // Execute in the cycle after accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= accept;
      out_valid_r <= busy_r;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      req_func_r <= in_func;
      req_seq_r  <= in_seq_num;
      req_len_r  <= in_data_length;
      req_fin_r  <= in_is_fin;
      req_need_r <= in_needs_ack;
      req_now_r  <= in_now_ms;
    end
  end

  // Timer and retry arithmetic on the head entry
  assign deadline_new = req_now_r + {32'd0, cfg_timeout};
  assign retry_inc    = {1'b0, head_entry.retries} + 9'd1;
  assign tick_due     = head_valid && (head_entry.deadline < req_now_r);
  assign give_up      = retry_inc > {1'b0, cfg_retry_limit};
  assign fin_give_up  = (retry_inc > {1'b0, cfg_fin_limit}) && head_entry.fin && !cfg_is_server;

  // Decide the table command and the result
  always_comb begin
    append      = 1'b0;
    drop_head   = 1'b0;
    rotate      = 1'b0;
    ack_rm      = 1'b0;
    ins.seq      = req_seq_r;
    ins.len      = req_len_r;
    ins.fin      = req_fin_r;
    ins.retries  = 8'd0;
    ins.deadline = deadline_new;
    ins.sum      = {1'b0, req_seq_r} + {23'd0, req_len_r};
    outcome_nxt = OC_IDLE;
    seq_nxt     = 32'd0;
    len_nxt     = 10'd0;
    fin_nxt     = 1'b0;
    retries_nxt = 8'd0;
    stop_nxt    = 1'b0;
    case (req_func_r)
      FUNC_SEND: begin
        seq_nxt     = req_seq_r;
        len_nxt     = req_len_r;
        fin_nxt     = req_fin_r;
        outcome_nxt = (req_need_r && full) ? OC_FULL : OC_TRANSMIT;
        append      = busy_r && req_need_r && !full;
      end
      FUNC_TICK: begin
        if (tick_due) begin
          seq_nxt     = head_entry.seq;
          len_nxt     = head_entry.len;
          fin_nxt     = head_entry.fin;
          retries_nxt = retry_inc[8] ? 8'hFF : retry_inc[7:0];
          if (give_up) begin
            drop_head   = busy_r;
            outcome_nxt = OC_GIVEN_UP;
            stop_nxt    = !cfg_is_server;
          end else if (fin_give_up) begin
            drop_head   = busy_r;
            outcome_nxt = OC_FIN_GIVEN_UP;
            stop_nxt    = 1'b1;
          end else begin
            rotate      = busy_r;
            outcome_nxt = OC_RETRANSMIT;
            ins         = head_entry;
            ins.retries = retry_inc[7:0];
            ins.deadline = deadline_new;
          end
        end
      end
      FUNC_ACK: begin
        if (any_hit) begin
          ack_rm      = busy_r;
          outcome_nxt = OC_ACKED;
          seq_nxt     = hit_entry.seq;
          len_nxt     = hit_entry.len;
          fin_nxt     = hit_entry.fin;
          retries_nxt = hit_entry.retries;
        end else begin
          outcome_nxt = OC_NO_MATCH;
        end
      end
      default: begin
        outcome_nxt = OC_IDLE;
      end
    endcase
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (busy_r) begin
      outcome_r <= outcome_nxt;
      seq_r     <= seq_nxt;
      len_r     <= len_nxt;
      fin_r     <= fin_nxt;
      retries_r <= retries_nxt;
      stop_r    <= stop_nxt;
    end
  end

  assign ctl.capture   = accept;
  assign ctl.ack       = in_ack_num;
  assign ctl.modulus   = cfg_modulus;
  assign ctl.append    = append;
  assign ctl.drop_head = drop_head;
  assign ctl.rotate    = rotate;
  assign ctl.ack_rm    = ack_rm;
  assign ctl.ins       = ins;

  assign busy             = busy_r;
  assign out_valid        = out_valid_r;
  assign out_outcome      = outcome_r;
  assign out_seq          = seq_r;
  assign out_length       = len_r;
  assign out_fin          = fin_r;
  assign out_retries      = retries_r;
  assign out_stop_request = stop_r;

endmodule

// ----- sim/rtq_checker.sv -----
// Scoreboard for the retransmit timer queue: mirrors the segment table and registers,
// predicts one outcome per accepted request and compares it with the result strobe.
// Depends on rtq_pkg for register indexes, request functions and outcome codes.
`timescale 1ns / 1ps
module rtq_checker
  import rtq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            in_func,
  input  logic [31:0]           in_seq_num,
  input  logic [9:0]            in_data_length,
  input  logic                  in_is_fin,
  input  logic                  in_needs_ack,
  input  logic [31:0]           in_ack_num,
  input  logic [47:0]           in_now_ms,
  input  logic                  out_valid,
  input  logic [2:0]            out_outcome,
  input  logic [31:0]           out_seq,
  input  logic [9:0]            out_length,
  input  logic                  out_fin,
  input  logic [7:0]            out_retries,
  input  logic                  out_stop_request,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    awaiting,
  output int                    checked
);

  typedef struct packed {
    logic [31:0] seq;
    logic [9:0]  len;
    logic        fin;
    logic [7:0]  retries;
    logic [47:0] deadline;
  } segment_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [31:0] seq;
    logic [9:0]  len;
    logic        fin;
    logic [7:0]  retries;
    logic        stop;
  } outcome_t;

  segment_t    tracked[$];
  outcome_t    pending_outcomes[$];
  logic        srv;
  logic [7:0]  retry_lim;
  logic [7:0]  fin_lim;
  logic [15:0] tmo;
  logic [32:0] modv;
  int          fails = 0;
  int          seen = 0;

  // Apply one request to the mirrored table and return the outcome it should produce
  function automatic outcome_t predict_outcome(logic [1:0] fn, logic [31:0] seq,
                                               logic [9:0] len, logic fin, logic need,
                                               logic [31:0] ack, logic [47:0] now);
    outcome_t res;
    segment_t seg;
    logic [8:0]  bumped;
    logic [32:0] sum;
    logic        hit;
    int          k;
    res = '0;
    res.outcome = OC_IDLE;
    hit = 1'b0;
    case (fn)
      FUNC_SEND: begin
        res.outcome = OC_TRANSMIT;
        res.seq = seq;
        res.len = len;
        res.fin = fin;
        if (need) begin
          if (tracked.size() >= RTQ_DEPTH) begin
            res.outcome = OC_FULL;
          end else begin
            seg.seq = seq;
            seg.len = len;
            seg.fin = fin;
            seg.retries = 8'd0;
            seg.deadline = now + 48'(tmo);
            tracked.insert(tracked.size(), seg);
          end
        end
      end
      FUNC_TICK: begin
        // only the head is ever checked, and only when strictly overdue
        if (tracked.size() > 0 && tracked[0].deadline < now) begin
          seg = tracked.pop_front();
          bumped = {1'b0, seg.retries} + 9'd1;
          res.seq = seg.seq;
          res.len = seg.len;
          res.fin = seg.fin;
          res.retries = bumped[8] ? 8'hFF : bumped[7:0];
          if (bumped > {1'b0, retry_lim}) begin
            res.outcome = OC_GIVEN_UP;
            res.stop = !srv;
          end else if (bumped > {1'b0, fin_lim} && seg.fin && !srv) begin
            res.outcome = OC_FIN_GIVEN_UP;
            res.stop = 1'b1;
          end else begin
            seg.retries = bumped[7:0];
            seg.deadline = now + 48'(tmo);
            tracked.insert(tracked.size(), seg);
            res.outcome = OC_RETRANSMIT;
          end
        end
      end
      FUNC_ACK: begin
        // oldest entry whose end sequence, reduced once, equals the ack wins
        res.outcome = OC_NO_MATCH;
        for (k = 0; k < tracked.size() && !hit; k++) begin
          sum = {1'b0, tracked[k].seq} + 33'(tracked[k].len);
          if (sum >= modv) sum = sum - modv;
          if (sum == {1'b0, ack}) begin
            hit = 1'b1;
            res.outcome = OC_ACKED;
            res.seq = tracked[k].seq;
            res.len = tracked[k].len;
            res.fin = tracked[k].fin;
            res.retries = tracked[k].retries;
            tracked.delete(k);
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t rtq mismatch on %s: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      tracked.delete();
      pending_outcomes.delete();
      srv = 1'b0;
      retry_lim = RETRY_LIMIT_RST;
      fin_lim = FIN_LIMIT_RST;
      tmo = TIMEOUT_RST;
      modv = MODULUS_RST;
    end else begin
      // check the strobed result against the oldest prediction
      if (out_valid) begin
        seen++;
        if (pending_outcomes.size() == 0) begin
          fails++;
          $display("%0t rtq unexpected result: expected none, got outcome %0d seq %0h",
                   $time, out_outcome, out_seq);
        end else begin
          want = pending_outcomes.pop_front();
          compare_field("outcome", 32'(want.outcome), 32'(out_outcome));
          compare_field("seq", want.seq, out_seq);
          compare_field("length", 32'(want.len), 32'(out_length));
          compare_field("fin", 32'(want.fin), 32'(out_fin));
          compare_field("retries", 32'(want.retries), 32'(out_retries));
          compare_field("stop_request", 32'(want.stop), 32'(out_stop_request));
        end
      end
      // predict every accepted request
      if (start && !busy)
        pending_outcomes.insert(pending_outcomes.size(),
                                predict_outcome(in_func, in_seq_num, in_data_length,
                                                in_is_fin, in_needs_ack, in_ack_num,
                                                in_now_ms));
      // track register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_IS_SERVER:   srv = cfg_wdata[0];
          CFG_RETRY_LIMIT: retry_lim = cfg_wdata[7:0];
          CFG_FIN_LIMIT:   fin_lim = cfg_wdata[7:0];
          CFG_TIMEOUT:     tmo = cfg_wdata[15:0];
          CFG_MODULUS:     modv = cfg_wdata[32:0];
          default: ;
        endcase
      end
    end
    awaiting <= pending_outcomes.size();
    fail_count <= fails;
    checked <= seen;
  end

endmodule

// ----- sim/retransmit_timer_queue_tb.sv -----
// Top of the retransmit timer queue testbench: clock, reset, request and register stimulus,
// watchdog and verdict. Depends on rtq_pkg, retransmit_timer_queue and rtq_checker.
`timescale 1ns / 1ps
module retransmit_timer_queue_tb;
  import rtq_pkg::*;

  localparam logic [1:0] FUNC_UNUSED    = 2'd3;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         PHASE_ITEMS    = 180;
  localparam int         POOL_DEPTH     = 24;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            in_func = FUNC_SEND;
  logic [31:0]           in_seq_num = '0;
  logic [9:0]            in_data_length = '0;
  logic                  in_is_fin = 1'b0;
  logic                  in_needs_ack = 1'b0;
  logic [31:0]           in_ack_num = '0;
  logic [47:0]           in_now_ms = '0;
  logic                  out_valid;
  logic [2:0]            out_outcome;
  logic [31:0]           out_seq;
  logic [9:0]            out_length;
  logic                  out_fin;
  logic [7:0]            out_retries;
  logic                  out_stop_request;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_IS_SERVER;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int awaiting;
  int checked;

  // stimulus-side view of the registers and the clock of the protocol
  logic [15:0] cur_tmo = TIMEOUT_RST;
  logic [32:0] cur_mod = MODULUS_RST;
  logic [47:0] cur_now = 48'd1000;
  logic [31:0] ack_pool[$];
  int          idle_pct = 0;
  int          quiet = 0;
  int          accepted = 0;
  int          settings = 1;
  int          idle_cycles = 0;

  retransmit_timer_queue u_dut (.*);

  rtq_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired at %0t with %0d results outstanding", $time, awaiting);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // hold start off for a random gap, with occasional bursts of back-to-back requests
  task automatic pace();
    if (quiet > 0) begin
      quiet--;
    end else if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end else if ($urandom_range(99) < 3) begin
      quiet = 16;
    end
  endtask

  // present one request and wait for it to be taken
  task automatic issue(logic [1:0] fn, logic [31:0] seq, logic [9:0] len, logic fin,
                       logic need, logic [31:0] ack, logic [47:0] now);
    in_func <= fn;
    in_seq_num <= seq;
    in_data_length <= len;
    in_is_fin <= fin;
    in_needs_ack <= need;
    in_ack_num <= ack;
    in_now_ms <= now;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    accepted++;
    pace();
  endtask

  // send a segment and remember the ack that would retire it
  task automatic send_seg(logic [31:0] seq, logic [9:0] len, logic fin, logic need,
                          logic [47:0] now);
    logic [32:0] sum;
    sum = {1'b0, seq} + 33'(len);
    if (sum >= cur_mod) sum = sum - cur_mod;
    if (need) begin
      ack_pool.insert(ack_pool.size(), sum[31:0]);
      if (ack_pool.size() > POOL_DEPTH) void'(ack_pool.pop_front());
    end
    issue(FUNC_SEND, seq, len, fin, need, $urandom, now);
  endtask

  // drain outstanding results, then write every register
  task automatic set_config(logic srv, logic [7:0] rlim, logic [7:0] flim,
                            logic [15:0] tmo, logic [32:0] modv);
    logic [CFG_DATA_W-1:0] vals[5];
    logic [CFG_IDX_W-1:0]  idxs[5];
    int i;
    start <= 1'b0;
    while (awaiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    idxs = '{CFG_IS_SERVER, CFG_RETRY_LIMIT, CFG_FIN_LIMIT, CFG_TIMEOUT, CFG_MODULUS};
    vals = '{33'(srv), 33'(rlim), 33'(flim), 33'(tmo), modv};
    for (i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idxs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_tmo = tmo;
    cur_mod = modv;
    settings++;
  endtask

  // one random request: mostly sends, ticks and acks that hit tracked segments
  task automatic random_request();
    logic [63:0] rnd;
    logic [31:0] ack;
    int roll;
    roll = $urandom_range(99);
    rnd = {$urandom, $urandom};
    if ($urandom_range(99) < 50)
      cur_now = cur_now + 48'($urandom_range(0, 3));
    else
      cur_now = cur_now + 48'($urandom_range(0, int'(cur_tmo) + int'(cur_tmo) / 2 + 2));
    if (roll < 40) begin
      send_seg($urandom, 10'($urandom_range(0, 1023)), 1'($urandom_range(1)),
               $urandom_range(99) < 80, cur_now);
    end else if (roll < 72) begin
      issue(FUNC_TICK, $urandom, 10'($urandom), 1'($urandom), 1'($urandom), $urandom,
            cur_now);
    end else if (roll < 96) begin
      if (ack_pool.size() > 0 && $urandom_range(99) < 75)
        ack = ack_pool[$urandom_range(0, ack_pool.size() - 1)];
      else
        ack = $urandom;
      issue(FUNC_ACK, $urandom, 10'($urandom), 1'($urandom), 1'($urandom), ack,
            rnd[47:0]);
    end else begin
      issue(FUNC_UNUSED, $urandom, 10'($urandom), 1'($urandom), 1'($urandom), $urandom,
            rnd[47:0]);
    end
  endtask

  task automatic run_phase(logic srv, logic [7:0] rlim, logic [7:0] flim, logic [15:0] tmo,
                           logic [32:0] modv, int idle, int count);
    int i;
    set_config(srv, rlim, flim, tmo, modv);
    idle_pct = idle;
    quiet = 0;
    for (i = 0; i < count; i++) random_request();
  endtask

  initial begin
    logic [63:0] base;
    int i;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset registers, empty table, extremes, full table, due and not due heads
    issue(FUNC_TICK, '0, '0, 1'b0, 1'b0, '0, cur_now);
    issue(FUNC_UNUSED, '1, '1, 1'b1, 1'b1, '1, '1);
    send_seg('0, '0, 1'b0, 1'b0, cur_now);
    send_seg('1, '1, 1'b1, 1'b0, cur_now);
    for (i = 0; i < RTQ_DEPTH; i++) begin
      if (i == RTQ_DEPTH - 1)
        send_seg('1, '1, 1'b1, 1'b1, cur_now);
      else
        send_seg(32'(i * 1500), 10'($urandom_range(0, 1023)), 1'(i), 1'b1, cur_now);
    end
    send_seg(32'h1234_5678, 10'd77, 1'b1, 1'b1, cur_now);
    issue(FUNC_TICK, '0, '0, 1'b0, 1'b0, '0, cur_now + 48'(cur_tmo));
    issue(FUNC_TICK, '0, '0, 1'b0, 1'b0, '0, cur_now + 48'(cur_tmo) + 48'd1);
    issue(FUNC_ACK, '0, '0, 1'b0, 1'b0, ack_pool[5], cur_now);
    issue(FUNC_ACK, '0, '0, 1'b0, 1'b0, '1, cur_now);

    // low extremes across the top of the time range, then give up everything left
    cur_now = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 200));
    run_phase(1'b0, 8'd0, 8'd0, 16'd1, 33'd1024, 0, PHASE_ITEMS);
    for (i = 0; i < RTQ_DEPTH + 1; i++)
      issue(FUNC_TICK, $urandom, '0, 1'b0, 1'b0, $urandom, '1);

    // one FIN segment retried until its count saturates and it is given up
    run_phase(1'b1, 8'd255, 8'd255, 16'd1, 33'h1_0000_0000, 0, 0);
    cur_now = '0;
    send_seg($urandom, 10'($urandom_range(0, 1023)), 1'b1, 1'b1, cur_now);
    for (i = 0; i < 257; i++) begin
      cur_now = cur_now + 48'd2;
      issue(FUNC_TICK, $urandom, '0, 1'b0, 1'b0, $urandom, cur_now);
    end

    // random phases over several register settings and idle patterns
    base = {$urandom, $urandom};
    cur_now = {2'b00, base[45:0]};
    run_phase(1'b1, 8'd255, 8'd255, 16'd65535, 33'h1_0000_0000, 61, PHASE_ITEMS);
    run_phase(1'b0, 8'd3, 8'd1, 16'd10, 33'd30720, 27, PHASE_ITEMS);
    run_phase(1'b1, 8'd2, 8'd0, 16'd5, 33'd4096, 0, PHASE_ITEMS);
    run_phase(1'b0, 8'd255, 8'd2, 16'd0, 33'd0, 61, PHASE_ITEMS);
    run_phase(1'b0, 8'd1, 8'd255, 16'd3, 33'h1_FFFF_FFFF, 27, PHASE_ITEMS);
    run_phase(1'b1, 8'd6, 8'd4, 16'd50, 33'd1024, 61, PHASE_ITEMS);
    run_phase(1'b0, 8'd4, 8'd2, 16'd7, 33'h1_0000_0000, 27, PHASE_ITEMS);

    // let the last results land, then give the verdict
    start <= 1'b0;
    while (awaiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Ran %0d requests under %0d register settings; %0d results compared.",
             accepted, settings, checked);
    $display("Covered full table, time wrap, retry saturation and client/server give-up.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches found", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
